/* rtl/pwh_pkg.sv */
// Shared types and constants for the PID controller with on/off hysteresis.
package pwh_pkg;

  // Configuration port geometry.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register map, by register index (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_BAND_WIDTH    = 3'd3,
    REG_PID_ENABLE    = 3'd4,
    REG_ONOFF_ENABLE  = 3'd5,
    REG_FORCE_ENABLE  = 3'd6,
    REG_FORCE_VALUE   = 3'd7
  } reg_index_t;

  // Largest forced drive that is honored (100.0 in Q16.16).
  localparam logic [22:0] FORCE_MAX = 23'd6553600;

  // 1.0 in Q16.16, added while the on/off output is on.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // The integral product is split at this bit of the error sum magnitude.
  localparam int SPLIT = 20;

  // Width of the accumulation of the drive terms.
  localparam int TOTAL_W = 64;

  // The integral term is clipped to plus or minus two to this power.
  localparam int TERM_SHIFT = 60;

  // Product limit in the high partial product, before the shift by SPLIT.
  localparam int HI_LIMIT_SHIFT = TERM_SHIFT - SPLIT;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integral_gain_step;
    logic signed [31:0] deriv_gain_step;
    logic [15:0]        band_width;
    logic               pid_enable;
    logic               onoff_enable;
    logic               force_enable;
    logic [22:0]        force_value;
  } cfg_t;

  // Per-item control flags carried down the pipeline.
  typedef struct packed {
    logic forced;
    logic pid;
    logic onoff_on;
    logic sat;
  } step_flags_t;

endpackage

/* rtl/pwh_cfg.sv */
// APB-style configuration registers and the state-clear strobe.
module pwh_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwh_pkg::ADDR_W-1:0]    paddr,
  input  logic [pwh_pkg::DATA_W-1:0]    pwdata,
  output logic [pwh_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output pwh_pkg::cfg_t                 cfg,
  output logic                          clear_state
);
  import pwh_pkg::*;

  logic       write_en;
  reg_index_t idx;

  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite && pready;
  assign idx      = reg_index_t'(paddr[ADDR_W-1:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (write_en) begin
      case (idx)
        REG_PROP_GAIN:    cfg.prop_gain          <= pwdata;
        REG_INTEG_GAIN:   cfg.integral_gain_step <= pwdata;
        REG_DERIV_GAIN:   cfg.deriv_gain_step    <= pwdata;
        REG_BAND_WIDTH:   cfg.band_width         <= pwdata[15:0];
        REG_PID_ENABLE:   cfg.pid_enable         <= pwdata[0];
        REG_ONOFF_ENABLE: cfg.onoff_enable       <= pwdata[0];
        REG_FORCE_ENABLE: cfg.force_enable       <= pwdata[0];
        REG_FORCE_VALUE:  cfg.force_value        <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  // Writing the integral or derivative gain, or the PID or on/off enable, clears the controller state.
  always_comb begin
    clear_state = 1'b0;
    case (idx)
      REG_INTEG_GAIN, REG_DERIV_GAIN, REG_PID_ENABLE, REG_ONOFF_ENABLE: clear_state = write_en;
      default: clear_state = 1'b0;
    endcase
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_PROP_GAIN:    prdata = cfg.prop_gain;
      REG_INTEG_GAIN:   prdata = cfg.integral_gain_step;
      REG_DERIV_GAIN:   prdata = cfg.deriv_gain_step;
      REG_BAND_WIDTH:   prdata = {16'b0, cfg.band_width};
      REG_PID_ENABLE:   prdata = {31'b0, cfg.pid_enable};
      REG_ONOFF_ENABLE: prdata = {31'b0, cfg.onoff_enable};
      REG_FORCE_ENABLE: prdata = {31'b0, cfg.force_enable};
      REG_FORCE_VALUE:  prdata = {9'b0, cfg.force_value};
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/pwh_err.sv */
// Input stage: error, saturating error sum, error difference, hysteresis, and state.
module pwh_err #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = 40
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pwh_pkg::cfg_t                     cfg,
  input  logic                              clear_state,
  input  logic                              load,
  input  logic signed [SAMPLE_BITS-1:0]     setpoint,
  input  logic signed [SAMPLE_BITS-1:0]     measurement,
  input  logic                              restart,
  output pwh_pkg::step_flags_t              flags,
  output logic signed [SAMPLE_BITS:0]       err,
  output logic signed [SUM_BITS-1:0]        sum,
  output logic signed [SAMPLE_BITS+1:0]     diff
);
  import pwh_pkg::*;

  localparam int E_W   = SAMPLE_BITS + 1;
  localparam int D_W   = SAMPLE_BITS + 2;
  localparam int CMP_W = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  // Controller state.
  logic signed [SUM_BITS-1:0] error_sum;
  logic signed [E_W-1:0]      previous_error;
  logic                       onoff_level;

  logic                       forced;
  logic signed [SUM_BITS-1:0] base_sum;
  logic signed [E_W-1:0]      base_prev;
  logic                       base_level;
  logic signed [E_W-1:0]      err_now;
  logic [SUM_BITS:0]          sum_wide;
  logic                       sum_ovf;
  logic signed [SUM_BITS-1:0] sum_now;
  logic signed [D_W-1:0]      diff_now;
  logic signed [CMP_W-1:0]    sp_x;
  logic signed [CMP_W-1:0]    ms_x;
  logic signed [CMP_W-1:0]    half_x;
  logic signed [CMP_W-1:0]    lo_th;
  logic signed [CMP_W-1:0]    hi_th;
  logic                       level_now;

  // Forcing holds the state and bypasses the controller.
  assign forced = cfg.force_enable && (cfg.force_value <= FORCE_MAX);

  // A restart starts the step from cleared state.
  assign base_sum   = restart ? '0 : error_sum;
  assign base_prev  = restart ? '0 : previous_error;
  assign base_level = restart ? 1'b0 : onoff_level;

  // Error and its difference to the previous error.
  assign err_now  = {setpoint[SAMPLE_BITS-1], setpoint}
                  - {measurement[SAMPLE_BITS-1], measurement};
  assign diff_now = {err_now[E_W-1], err_now} - {base_prev[E_W-1], base_prev};

  // Saturating accumulation of the error.
  assign sum_wide = {base_sum[SUM_BITS-1], base_sum}
                  + {{(SUM_BITS+1-E_W){err_now[E_W-1]}}, err_now};
  assign sum_ovf  = sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1];
  assign sum_now  = !sum_ovf ? sum_wide[SUM_BITS-1:0]
                  : (sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX);

  // On/off part with a hysteresis of half the band on either side.
  assign sp_x   = {{(CMP_W-SAMPLE_BITS){setpoint[SAMPLE_BITS-1]}}, setpoint};
  assign ms_x   = {{(CMP_W-SAMPLE_BITS){measurement[SAMPLE_BITS-1]}}, measurement};
  assign half_x = {{(CMP_W-15){1'b0}}, cfg.band_width[15:1]};
  assign lo_th  = sp_x - half_x;
  assign hi_th  = sp_x + half_x;
  always_comb begin
    if (ms_x < lo_th) begin
      level_now = 1'b1;
    end else if (ms_x > hi_th) begin
      level_now = 1'b0;
    end else begin
      level_now = base_level;
    end
  end

  // State update on each accepted, unforced transaction.
  always_ff @(posedge clk) begin
    if (rst || clear_state) begin
      error_sum      <= '0;
      previous_error <= '0;
      onoff_level    <= 1'b0;
    end else if (load && !forced) begin
      error_sum      <= cfg.pid_enable ? sum_now : base_sum;
      previous_error <= cfg.pid_enable ? err_now : base_prev;
      onoff_level    <= cfg.onoff_enable ? level_now : base_level;
    end
  end

  // Stage register toward the multipliers.
  always_ff @(posedge clk) begin
    if (load) begin
      flags.forced   <= forced;
      flags.pid      <= cfg.pid_enable;
      flags.onoff_on <= cfg.onoff_enable && level_now;
      flags.sat      <= cfg.pid_enable && sum_ovf;
      err            <= err_now;
      sum            <= sum_now;
      diff           <= diff_now;
    end
  end

endmodule

/* rtl/pwh_mult.sv */
// Multiplier stage: proportional, derivative and split integral products.
module pwh_mult #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = 40
) (
  input  logic                                          clk,
  input  pwh_pkg::cfg_t                                 cfg,
  input  logic                                          load,
  input  pwh_pkg::step_flags_t                          flags_in,
  input  logic signed [SAMPLE_BITS:0]                   err,
  input  logic signed [SUM_BITS-1:0]                    sum,
  input  logic signed [SAMPLE_BITS+1:0]                 diff,
  output pwh_pkg::step_flags_t                          flags,
  output logic signed [SAMPLE_BITS+32:0]                prop_p,
  output logic signed [SAMPLE_BITS+33:0]                deriv_p,
  output logic [32+SUM_BITS-pwh_pkg::SPLIT-1:0]         integ_hi,
  output logic [32+pwh_pkg::SPLIT-1:0]                  integ_lo,
  output logic                                          integ_neg
);
  import pwh_pkg::*;

  localparam int P_W  = SAMPLE_BITS + 33;
  localparam int D_W  = SAMPLE_BITS + 34;
  localparam int HI_W = 32 + SUM_BITS - SPLIT;
  localparam int LO_W = 32 + SPLIT;

  logic [31:0]           gain_mag;
  logic [SUM_BITS-1:0]   sum_mag;
  logic signed [P_W-1:0] prop_now;
  logic signed [D_W-1:0] deriv_now;
  logic [HI_W-1:0]       hi_now;
  logic [LO_W-1:0]       lo_now;

  // Magnitudes for the integral product; its sign travels separately.
  assign gain_mag = cfg.integral_gain_step[31] ? (~cfg.integral_gain_step + 32'd1)
                                               : cfg.integral_gain_step;
  assign sum_mag  = sum[SUM_BITS-1] ? (~sum + SUM_BITS'(1)) : sum;

  // Products.
  assign prop_now  = P_W'(cfg.prop_gain) * P_W'(err);
  assign deriv_now = D_W'(cfg.deriv_gain_step) * D_W'(diff);
  assign hi_now    = HI_W'(gain_mag) * HI_W'(sum_mag[SUM_BITS-1:SPLIT]);
  assign lo_now    = LO_W'(gain_mag) * LO_W'(sum_mag[SPLIT-1:0]);

  // Stage register toward the summation.
  always_ff @(posedge clk) begin
    if (load) begin
      flags     <= flags_in;
      prop_p    <= prop_now;
      deriv_p   <= deriv_now;
      integ_hi  <= hi_now;
      integ_lo  <= lo_now;
      integ_neg <= cfg.integral_gain_step[31] ^ sum[SUM_BITS-1];
    end
  end

endmodule

/* rtl/pwh_out.sv */
// Output stage: integral clip, term summation, output saturation and result register.
module pwh_out #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = 40
) (
  input  logic                                          clk,
  input  pwh_pkg::cfg_t                                 cfg,
  input  logic                                          load,
  input  pwh_pkg::step_flags_t                          flags,
  input  logic signed [SAMPLE_BITS+32:0]                prop_p,
  input  logic signed [SAMPLE_BITS+33:0]                deriv_p,
  input  logic [32+SUM_BITS-pwh_pkg::SPLIT-1:0]         integ_hi,
  input  logic [32+pwh_pkg::SPLIT-1:0]                  integ_lo,
  input  logic                                          integ_neg,
  output logic signed [31:0]                            drive,
  output logic                                          saturated
);
  import pwh_pkg::*;

  localparam int P_W  = SAMPLE_BITS + 33;
  localparam int D_W  = SAMPLE_BITS + 34;
  localparam int HI_W = 32 + SUM_BITS - SPLIT;
  localparam int LO_W = 32 + SPLIT;
  localparam logic [TOTAL_W-1:0] TERM_LIMIT = TOTAL_W'(1) << TERM_SHIFT;
  localparam logic [TOTAL_W-1:0] HI_LIMIT   = TOTAL_W'(1) << HI_LIMIT_SHIFT;
  localparam logic signed [TOTAL_W-1:0] OUT_MAX = TOTAL_W'(32'h7FFF_FFFF);
  localparam logic signed [TOTAL_W-1:0] OUT_MIN = -(TOTAL_W'(64'h8000_0000));

  logic [TOTAL_W-1:0]        hi_x;
  logic [TOTAL_W-1:0]        lo_x;
  logic [TOTAL_W-1:0]        mag;
  logic [TOTAL_W-1:0]        mag_clip;
  logic signed [TOTAL_W-1:0] integ_term;
  logic signed [TOTAL_W-1:0] prop_x;
  logic signed [TOTAL_W-1:0] deriv_x;
  logic signed [TOTAL_W-1:0] pid_sum;
  logic signed [TOTAL_W-1:0] total;
  logic signed [31:0]        drive_next;
  logic                      saturated_next;

  // Integral term, clipped to the term limit.
  assign hi_x     = {{(TOTAL_W-HI_W){1'b0}}, integ_hi};
  assign lo_x     = {{(TOTAL_W-LO_W){1'b0}}, integ_lo};
  assign mag      = (hi_x << SPLIT) + lo_x;
  assign mag_clip = ((hi_x >= HI_LIMIT) || (mag > TERM_LIMIT)) ? TERM_LIMIT : mag;
  assign integ_term = integ_neg ? -mag_clip : mag_clip;

  // Sum of the enabled terms.
  assign prop_x  = {{(TOTAL_W-P_W){prop_p[P_W-1]}}, prop_p};
  assign deriv_x = {{(TOTAL_W-D_W){deriv_p[D_W-1]}}, deriv_p};
  assign pid_sum = flags.pid ? (prop_x + deriv_x + integ_term) : '0;
  assign total   = pid_sum + (flags.onoff_on ? TOTAL_W'(ONE_Q16) : '0);

  // Saturation to 32 bits, or the forced value.
  always_comb begin
    if (flags.forced) begin
      drive_next     = {9'b0, cfg.force_value};
      saturated_next = 1'b0;
    end else if (total > OUT_MAX) begin
      drive_next     = OUT_MAX[31:0];
      saturated_next = 1'b1;
    end else if (total < OUT_MIN) begin
      drive_next     = OUT_MIN[31:0];
      saturated_next = 1'b1;
    end else begin
      drive_next     = total[31:0];
      saturated_next = flags.sat;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      drive     <= drive_next;
      saturated <= saturated_next;
    end
  end

endmodule

/* rtl/pid_with_onoff_hysteresis.sv */
// Discrete PID controller with an on/off hysteresis term, top level.
//
// Input stream (s_*): one transaction carries a setpoint and a measurement
// in s_tdata and a restart flag in s_tuser. Output stream (m_*): one
// transaction per input carries the drive value (signed Q16.16) in m_tdata
// and the saturation flag in m_tuser.
// The APB-style port writes the gains, the hysteresis band, the enables and
// the forced value; configure only while no transaction is in flight.
//
// The datapath is three register stages: error and state update, the
// multipliers, then summation and output saturation. A result passes
// through the error, multiplier and result registers in turn, and one input
// is accepted every cycle unless m_tready holds the pipeline. The error sum
// is updated in the first stage, so a following transaction sees it at once.
// When m_tready is low the result register holds; the stages behind it keep
// accepting until they are full, then s_tready drops.
// Reset clears the configuration registers, the error sum, the previous error and the
// on/off output, and empties the pipeline.
module pid_with_onoff_hysteresis #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = 40
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // s_tdata: setpoint, measurement
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            s_tdata,
  // s_tuser: restart
  input  logic                                          s_tuser,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // m_tdata: drive
  output logic [31:0]                                   m_tdata,
  // m_tuser: saturated
  output logic                                          m_tuser,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [pwh_pkg::ADDR_W-1:0]                    paddr,
  input  logic [pwh_pkg::DATA_W-1:0]                    pwdata,
  output logic [pwh_pkg::DATA_W-1:0]                    prdata,
  output logic                                          pready
);
  import pwh_pkg::*;

  localparam int HI_W = 32 + SUM_BITS - SPLIT;
  localparam int LO_W = 32 + SPLIT;

  cfg_t                         cfg;
  logic                         clear_state;
  logic                         valid1;
  logic                         valid2;
  logic                         ready1;
  logic                         ready2;
  logic                         ready3;
  logic                         load1;
  logic                         load2;
  logic                         load3;
  step_flags_t                  flags1;
  step_flags_t                  flags2;
  logic signed [SAMPLE_BITS:0]   err1;
  logic signed [SUM_BITS-1:0]    sum1;
  logic signed [SAMPLE_BITS+1:0] diff1;
  logic signed [SAMPLE_BITS+32:0] prop2;
  logic signed [SAMPLE_BITS+33:0] deriv2;
  logic [HI_W-1:0]              hi2;
  logic [LO_W-1:0]              lo2;
  logic                         neg2;
  logic signed [31:0]           drive;

  // Pipeline flow control: a stage loads when it is empty or its successor moves.
  assign ready3   = !m_tvalid || m_tready;
  assign ready2   = !valid2 || ready3;
  assign ready1   = !valid1 || ready2;
  assign s_tready = ready1;
  assign load1    = s_tvalid && ready1;
  assign load2    = valid1 && ready2;
  assign load3    = valid2 && ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1   <= 1'b0;
      valid2   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      valid1   <= load1 || (valid1 && !ready2);
      valid2   <= load2 || (valid2 && !ready3);
      m_tvalid <= load3 || (m_tvalid && !m_tready);
    end
  end

  pwh_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg         (cfg),
    .clear_state (clear_state)
  );

  pwh_err #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_err (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clear_state (clear_state),
    .load        (load1),
    .setpoint    (s_tdata[SAMPLE_BITS-1:0]),
    .measurement (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .restart     (s_tuser),
    .flags       (flags1),
    .err         (err1),
    .sum         (sum1),
    .diff        (diff1)
  );

  pwh_mult #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_mult (
    .clk       (clk),
    .cfg       (cfg),
    .load      (load2),
    .flags_in  (flags1),
    .err       (err1),
    .sum       (sum1),
    .diff      (diff1),
    .flags     (flags2),
    .prop_p    (prop2),
    .deriv_p   (deriv2),
    .integ_hi  (hi2),
    .integ_lo  (lo2),
    .integ_neg (neg2)
  );

  pwh_out #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_out (
    .clk       (clk),
    .cfg       (cfg),
    .load      (load3),
    .flags     (flags2),
    .prop_p    (prop2),
    .deriv_p   (deriv2),
    .integ_hi  (hi2),
    .integ_lo  (lo2),
    .integ_neg (neg2),
    .drive     (drive),
    .saturated (m_tuser)
  );

  assign m_tdata = drive;

endmodule
